[rtl/hsv_to_rgb_converter_defines.svh]
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared assertion forms for the converter's RTL files.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define HSV2RGB_ASSERT_SAME(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Check a consequence in the cycle after its condition.
`define HSV2RGB_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[rtl/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Fixed-point widths, hue constants and the transfer payload types.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   // Fraction format: ONE stands for 1.0
   localparam int FRACTION_BITS = 8;
   localparam int FRAC_WIDTH    = FRACTION_BITS + 1;
   localparam logic [FRAC_WIDTH-1:0] FRAC_ONE = FRAC_WIDTH'(1) << FRACTION_BITS;

   // Hue in 1/16 degree, one 60 degree sector spans 960 units
   localparam int HUE_WIDTH    = 13;
   localparam int SECTOR_UNITS = 960;
   localparam int WEIGHT_WIDTH = $clog2(SECTOR_UNITS + 1);
   localparam logic [HUE_WIDTH-1:0] HUE_MAX = HUE_WIDTH'(6 * SECTOR_UNITS - 1);

   typedef struct packed {
      logic [HUE_WIDTH-1:0]  hue;
      logic [FRAC_WIDTH-1:0] saturation;
      logic [FRAC_WIDTH-1:0] brightness;
   } hsv2rgb_req_type;

   typedef struct packed {
      logic [FRAC_WIDTH-1:0] red;
      logic [FRAC_WIDTH-1:0] green;
      logic [FRAC_WIDTH-1:0] blue;
   } hsv2rgb_rsp_type;

endpackage

[rtl/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Pipelined fixed-point conversion of one HSV pixel to one RGB pixel.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+---------------------------------
//  req     | in        | req_valid/req_ready | req_data: hue, saturation, brightness
//  rsp     | out       | rsp_valid/rsp_ready | rsp_data: red, green, blue
//
//  Six register stages, st1 to st5 and the output register rsp; one pixel is
//  taken every cycle unless a result waits in a stalled output register.
//  The stage depth is set by the chroma multiply, the sector weight multiply
//  and the reciprocal multiply that divides by the sector width.
//  All stages advance together whenever the output register is empty or taken;
//  a stalled output holds every stage and nothing is lost or repeated.
//  Reset clears the stage valid bits only; no clearing pass is needed.
//
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  hsv2rgb_pkg::hsv2rgb_req_type req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output hsv2rgb_pkg::hsv2rgb_rsp_type rsp_data
);
   import hsv2rgb_pkg::*;

   // Product and reciprocal widths for the divide by the sector width
   localparam int PROD_WIDTH  = FRAC_WIDTH + WEIGHT_WIDTH;
   localparam int RECIP_WIDTH = PROD_WIDTH - 9;
   localparam logic [RECIP_WIDTH-1:0] SECTOR_RECIP =
      RECIP_WIDTH'((64'(1) << PROD_WIDTH) / SECTOR_UNITS);
   localparam logic [WEIGHT_WIDTH-1:0] SECTOR_SPAN = WEIGHT_WIDTH'(SECTOR_UNITS);

   typedef enum logic [2:0] {
      SEC_RED_YELLOW   = 3'd0,
      SEC_YELLOW_GREEN = 3'd1,
      SEC_GREEN_CYAN   = 3'd2,
      SEC_CYAN_BLUE    = 3'd3,
      SEC_BLUE_MAGENTA = 3'd4,
      SEC_MAGENTA_RED  = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type              sector;
      logic [WEIGHT_WIDTH-1:0] weight;
      logic [FRAC_WIDTH-1:0]   sat;
      logic [FRAC_WIDTH-1:0]   val;
   } st1_type;

   typedef struct packed {
      sector_type              sector;
      logic [WEIGHT_WIDTH-1:0] weight;
      logic [FRAC_WIDTH-1:0]   val;
      logic [2*FRAC_WIDTH-1:0] chroma_full;
   } st2_type;

   typedef struct packed {
      sector_type            sector;
      logic [FRAC_WIDTH-1:0] val;
      logic [FRAC_WIDTH-1:0] chroma;
      logic [PROD_WIDTH-1:0] prod;
   } st3_type;

   typedef struct packed {
      sector_type            sector;
      logic [FRAC_WIDTH-1:0] val;
      logic [FRAC_WIDTH-1:0] chroma;
      logic [PROD_WIDTH-1:0] prod;
      logic [FRAC_WIDTH-1:0] est;
   } st4_type;

   typedef struct packed {
      sector_type            sector;
      logic [FRAC_WIDTH-1:0] chroma;
      logic [FRAC_WIDTH-1:0] second;
      logic [FRAC_WIDTH-1:0] offset;
   } st5_type;

   logic            advance;
   logic [4:0]      valid_ff;
   logic [4:0]      valid_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   st1_type         st1_ff, st1_in;
   st2_type         st2_ff, st2_in;
   st3_type         st3_ff, st3_in;
   st4_type         st4_ff, st4_in;
   st5_type         st5_ff, st5_in;
   hsv2rgb_rsp_type rsp_ff, rsp_in;

   logic [HUE_WIDTH-1:0]            hue_sat;
   logic [HUE_WIDTH-1:0]            sector_base;
   logic [WEIGHT_WIDTH-1:0]         offset_in_sector;
   logic [PROD_WIDTH+RECIP_WIDTH-1:0] recip_prod;
   logic [PROD_WIDTH-1:0]           remainder;

   // Advance all stages when the output register is free or being taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign valid_in     = {valid_ff[3:0], req_valid};
   assign rsp_valid_in = valid_ff[4];

   // Stage 1: limit inputs, find the sector and the weight within it
   always_comb begin
      hue_sat    = (req_data.hue > HUE_MAX) ? HUE_MAX : req_data.hue;
      st1_in.sat = (req_data.saturation > FRAC_ONE) ? FRAC_ONE : req_data.saturation;
      st1_in.val = (req_data.brightness > FRAC_ONE) ? FRAC_ONE : req_data.brightness;
      if (hue_sat >= HUE_WIDTH'(5 * SECTOR_UNITS)) begin
         st1_in.sector = SEC_MAGENTA_RED;
      end else if (hue_sat >= HUE_WIDTH'(4 * SECTOR_UNITS)) begin
         st1_in.sector = SEC_BLUE_MAGENTA;
      end else if (hue_sat >= HUE_WIDTH'(3 * SECTOR_UNITS)) begin
         st1_in.sector = SEC_CYAN_BLUE;
      end else if (hue_sat >= HUE_WIDTH'(2 * SECTOR_UNITS)) begin
         st1_in.sector = SEC_GREEN_CYAN;
      end else if (hue_sat >= HUE_WIDTH'(SECTOR_UNITS)) begin
         st1_in.sector = SEC_YELLOW_GREEN;
      end else begin
         st1_in.sector = SEC_RED_YELLOW;
      end
      case (st1_in.sector)
         SEC_RED_YELLOW:   sector_base = '0;
         SEC_YELLOW_GREEN: sector_base = HUE_WIDTH'(SECTOR_UNITS);
         SEC_GREEN_CYAN:   sector_base = HUE_WIDTH'(2 * SECTOR_UNITS);
         SEC_CYAN_BLUE:    sector_base = HUE_WIDTH'(3 * SECTOR_UNITS);
         SEC_BLUE_MAGENTA: sector_base = HUE_WIDTH'(4 * SECTOR_UNITS);
         default:          sector_base = HUE_WIDTH'(5 * SECTOR_UNITS);
      endcase
      offset_in_sector = WEIGHT_WIDTH'(hue_sat - sector_base);
      // Rising sectors weight by offset, falling sectors by distance to the end
      st1_in.weight = st1_in.sector[0] ? (SECTOR_SPAN - offset_in_sector)
                                       : offset_in_sector;
   end

   // Stage 2: chroma product
   always_comb begin
      st2_in.sector      = st1_ff.sector;
      st2_in.weight      = st1_ff.weight;
      st2_in.val         = st1_ff.val;
      st2_in.chroma_full = (2*FRAC_WIDTH)'(st1_ff.val) * (2*FRAC_WIDTH)'(st1_ff.sat);
   end

   // Stage 3: truncate chroma, scale it by the sector weight
   always_comb begin
      st3_in.sector = st2_ff.sector;
      st3_in.val    = st2_ff.val;
      st3_in.chroma = st2_ff.chroma_full[FRACTION_BITS +: FRAC_WIDTH];
      st3_in.prod   = PROD_WIDTH'(st3_in.chroma) * PROD_WIDTH'(st2_ff.weight);
   end

   // Stage 4: estimate the quotient by the sector width with a reciprocal
   always_comb begin
      recip_prod    = (PROD_WIDTH+RECIP_WIDTH)'(st3_ff.prod)
                    * (PROD_WIDTH+RECIP_WIDTH)'(SECTOR_RECIP);
      st4_in.sector = st3_ff.sector;
      st4_in.val    = st3_ff.val;
      st4_in.chroma = st3_ff.chroma;
      st4_in.prod   = st3_ff.prod;
      st4_in.est    = recip_prod[PROD_WIDTH +: FRAC_WIDTH];
   end

   // Stage 5: correct the estimate, which is at most one low; form the offset
   always_comb begin
      remainder     = st4_ff.prod - PROD_WIDTH'(st4_ff.est) * PROD_WIDTH'(SECTOR_UNITS);
      st5_in.sector = st4_ff.sector;
      st5_in.chroma = st4_ff.chroma;
      st5_in.second = (remainder >= PROD_WIDTH'(SECTOR_UNITS)) ? st4_ff.est + 1'b1
                                                               : st4_ff.est;
      st5_in.offset = st4_ff.val - st4_ff.chroma;
   end

   // Output stage: permute chroma and secondary by sector, add the offset
   always_comb begin
      case (st5_ff.sector)
         SEC_RED_YELLOW: begin
            rsp_in.red   = st5_ff.chroma + st5_ff.offset;
            rsp_in.green = st5_ff.second + st5_ff.offset;
            rsp_in.blue  = st5_ff.offset;
         end
         SEC_YELLOW_GREEN: begin
            rsp_in.red   = st5_ff.second + st5_ff.offset;
            rsp_in.green = st5_ff.chroma + st5_ff.offset;
            rsp_in.blue  = st5_ff.offset;
         end
         SEC_GREEN_CYAN: begin
            rsp_in.red   = st5_ff.offset;
            rsp_in.green = st5_ff.chroma + st5_ff.offset;
            rsp_in.blue  = st5_ff.second + st5_ff.offset;
         end
         SEC_CYAN_BLUE: begin
            rsp_in.red   = st5_ff.offset;
            rsp_in.green = st5_ff.second + st5_ff.offset;
            rsp_in.blue  = st5_ff.chroma + st5_ff.offset;
         end
         SEC_BLUE_MAGENTA: begin
            rsp_in.red   = st5_ff.second + st5_ff.offset;
            rsp_in.green = st5_ff.offset;
            rsp_in.blue  = st5_ff.chroma + st5_ff.offset;
         end
         default: begin
            rsp_in.red   = st5_ff.chroma + st5_ff.offset;
            rsp_in.green = st5_ff.offset;
            rsp_in.blue  = st5_ff.second + st5_ff.offset;
         end
      endcase
   end

   // Clear valid bits under reset, shift them with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance stage payloads; hold them on a stall
   always_ff @(posedge clock) begin
      if (advance) begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         st4_ff <= st4_in;
         st5_ff <= st5_in;
         rsp_ff <= rsp_in;
      end
   end

   // Assertions
   `HSV2RGB_ASSERT_NEXT(a_req_enters, clock, reset, req_valid && req_ready, valid_ff[0], "accepted request did not enter stage 1")
   `HSV2RGB_ASSERT_SAME(a_weight_range, clock, reset, valid_ff[0], st1_ff.weight <= SECTOR_SPAN, "sector weight exceeds sector width")
   `HSV2RGB_ASSERT_SAME(a_second_le_chroma, clock, reset, valid_ff[4], st5_ff.second <= st5_ff.chroma, "secondary component exceeds chroma")
   `HSV2RGB_ASSERT_SAME(a_out_range, clock, reset, rsp_valid, (rsp_data.red <= FRAC_ONE) && (rsp_data.green <= FRAC_ONE) && (rsp_data.blue <= FRAC_ONE), "result component exceeds one")

endmodule

[tb/hsv_to_rgb_converter_test.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Sends HSV pixels through the converter and checks each RGB result against
// a fixed-point color predictor over three phases, each ending in a full drain.
// Both channels idle and stall at random in the first two, the last has one long output stall.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;
   import hsv2rgb_pkg::*;

   // Hue sectors of 60 degrees, in hue order
   typedef enum int unsigned {
      SEC_RED_YELLOW,
      SEC_YELLOW_GREEN,
      SEC_GREEN_CYAN,
      SEC_CYAN_BLUE,
      SEC_BLUE_MAGENTA,
      SEC_MAGENTA_RED
   } hue_sector_type;

   // Idle patterns of sender and receiver
   typedef enum int unsigned {
      IDLE_SENDER_LIGHT,
      IDLE_RECEIVER_LIGHT,
      IDLE_NONE
   } idle_mode_type;

   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 12;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   hsv2rgb_req_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   hsv2rgb_rsp_type rsp_data;

   hsv2rgb_req_type pixel_queue[$];
   hsv2rgb_rsp_type rgb_expected[$];
   hsv2rgb_rsp_type rgb_want;
   idle_mode_type   idle_mode = IDLE_SENDER_LIGHT;
   bit              req_taken = 1'b0;
   bit              hold_off_req = 1'b0;
   bit              hold_done = 1'b0;
   int              hold_left = 0;
   int              quiet_cycles = 0;
   int              mismatches = 0;

   hsv_to_rgb_converter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Clock: 2 high, 2 low
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Expected RGB for one HSV pixel, truncating fixed point
   function automatic hsv2rgb_rsp_type rgb_from_hsv(hsv2rgb_req_type px);
      int unsigned     h;
      int unsigned     s;
      int unsigned     v;
      int unsigned     chroma;
      int unsigned     second;
      int unsigned     offset;
      int unsigned     pos;
      int unsigned     hue_gap;
      int unsigned     r;
      int unsigned     g;
      int unsigned     b;
      hue_sector_type  sector;
      hsv2rgb_rsp_type rgb;
      h = px.hue;
      s = px.saturation;
      v = px.brightness;
      // clamp inputs to their legal ranges
      if (h > HUE_MAX) h = HUE_MAX;
      if (s > FRAC_ONE) s = FRAC_ONE;
      if (v > FRAC_ONE) v = FRAC_ONE;
      chroma  = (v * s) >> FRACTION_BITS;
      pos     = h % (2 * SECTOR_UNITS);
      hue_gap = (pos >= SECTOR_UNITS) ? pos - SECTOR_UNITS : SECTOR_UNITS - pos;
      second  = (chroma * (SECTOR_UNITS - hue_gap)) / SECTOR_UNITS;
      offset  = v - chroma;
      sector  = hue_sector_type'(h / SECTOR_UNITS);
      case (sector)
         SEC_RED_YELLOW: begin
            r = chroma; g = second; b = 0;
         end
         SEC_YELLOW_GREEN: begin
            r = second; g = chroma; b = 0;
         end
         SEC_GREEN_CYAN: begin
            r = 0; g = chroma; b = second;
         end
         SEC_CYAN_BLUE: begin
            r = 0; g = second; b = chroma;
         end
         SEC_BLUE_MAGENTA: begin
            r = second; g = 0; b = chroma;
         end
         default: begin
            r = chroma; g = 0; b = second;
         end
      endcase
      rgb.red   = FRAC_WIDTH'(r + offset);
      rgb.green = FRAC_WIDTH'(g + offset);
      rgb.blue  = FRAC_WIDTH'(b + offset);
      return rgb;
   endfunction

   // Random pixel: mostly legal, some out-of-range hue and fractions
   function automatic hsv2rgb_req_type random_pixel();
      hsv2rgb_req_type px;
      case ($urandom_range(9))
         0: px.hue = HUE_WIDTH'($urandom);
         1: px.hue = HUE_WIDTH'($urandom_range(6) * SECTOR_UNITS + $urandom_range(3) - 2);
         default: px.hue = HUE_WIDTH'($urandom_range(HUE_MAX));
      endcase
      case ($urandom_range(7))
         0: px.saturation = FRAC_WIDTH'($urandom);
         1: px.saturation = FRAC_ONE;
         default: px.saturation = FRAC_WIDTH'($urandom_range(FRAC_ONE));
      endcase
      case ($urandom_range(7))
         0: px.brightness = FRAC_WIDTH'($urandom);
         1: px.brightness = FRAC_ONE;
         default: px.brightness = FRAC_WIDTH'($urandom_range(FRAC_ONE));
      endcase
      return px;
   endfunction

   function automatic bit idle_roll(int unsigned percent);
      return $urandom_range(99) < percent;
   endfunction

   task automatic queue_pixel(int unsigned h, int unsigned s, int unsigned v);
      hsv2rgb_req_type px;
      px.hue        = HUE_WIDTH'(h);
      px.saturation = FRAC_WIDTH'(s);
      px.brightness = FRAC_WIDTH'(v);
      pixel_queue.push_back(px);
   endtask

   task automatic queue_random(int count);
      repeat (count) pixel_queue.push_back(random_pixel());
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Hold until every queued pixel is sent and every result has come back
   task automatic drain();
      while (pixel_queue.size() != 0 || req_valid || rgb_expected.size() != 0)
         @(posedge clock);
   endtask

   // Driver: offer the next pixel at the falling edge, hold until transfer
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pixel_queue.size() != 0 &&
             !idle_roll(idle_mode == IDLE_SENDER_LIGHT ? 8 :
                        idle_mode == IDLE_RECEIVER_LIGHT ? 57 : 0)) begin
            req_data  <= pixel_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_off_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_roll(idle_mode == IDLE_SENDER_LIGHT ? 57 :
                                 idle_mode == IDLE_RECEIVER_LIGHT ? 8 : 0);
      end
   end

   // Monitor: predict on input transfer, compare on output transfer
   always @(posedge clock) begin
      req_taken = req_valid && req_ready;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_taken) rgb_expected.push_back(rgb_from_hsv(req_data));
         if (rsp_valid && rsp_ready) begin
            if (rgb_expected.size() == 0) begin
               $error("unexpected result: red %0d green %0d blue %0d",
                      rsp_data.red, rsp_data.green, rsp_data.blue);
               mismatches++;
            end else begin
               rgb_want = rgb_expected.pop_front();
               check_field("red",   rgb_want.red,   rsp_data.red);
               check_field("green", rgb_want.green, rsp_data.green);
               check_field("blue",  rgb_want.blue,  rsp_data.blue);
            end
         end
         if (req_taken || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles = quiet_cycles + 1;
      end
   end

   // Watchdog: end the run when transfers stop
   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("hsv_to_rgb_converter_test: FAIL");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: sector edges, clamped hue, zero and full fractions,
      // fractions above one
      idle_mode = IDLE_SENDER_LIGHT;
      queue_pixel(0,    256, 256);
      queue_pixel(959,  256, 256);
      queue_pixel(960,  256, 256);
      queue_pixel(1919, 256, 256);
      queue_pixel(1920, 256, 256);
      queue_pixel(2879, 256, 256);
      queue_pixel(2880, 256, 256);
      queue_pixel(3839, 256, 256);
      queue_pixel(3840, 256, 256);
      queue_pixel(4799, 256, 256);
      queue_pixel(4800, 256, 256);
      queue_pixel(5759, 256, 256);
      queue_pixel(5760, 256, 256);
      queue_pixel(8191, 256, 256);
      queue_pixel(480,  0,   256);
      queue_pixel(480,  256, 0);
      queue_pixel(480,  0,   0);
      queue_pixel(1440, 511, 511);
      queue_pixel(2400, 257, 300);
      queue_pixel(3360, 128, 256);
      queue_pixel(4320, 256, 128);
      queue_pixel(5280, 511, 200);
      queue_pixel(100,  200, 511);
      queue_random(600);
      drain();

      // Swap the idle roles after a full pause
      idle_mode = IDLE_RECEIVER_LIGHT;
      queue_random(500);
      drain();

      // No idling, with one long output stall to back up the pipeline
      idle_mode = IDLE_NONE;
      queue_random(500);
      hold_off_req = 1'b1;
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("hsv_to_rgb_converter_test: PASS");
      end else begin
         $display("hsv_to_rgb_converter_test: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/hsv2rgb_pkg.sv
rtl/hsv_to_rgb_converter.sv
tb/hsv_to_rgb_converter_test.sv
